### sv/hrlp_pkg.sv
// package: types, constants and helper functions of the request line parser
`timescale 1ns / 1ps

package hrlp_pkg;

    // line length limit and the offset counter that follows from it
    localparam int MAX_LINE_BYTES = 8192;
    localparam int OFF_W          = $clog2(MAX_LINE_BYTES);
    localparam logic [OFF_W-1:0] OFFSET_MAX = OFF_W'(MAX_LINE_BYTES - 1);

    // result field widths
    localparam int STATUS_W  = 2;
    localparam int METHOD_W  = 2;
    localparam int VER_W     = 10;
    localparam int OUT_OFF_W = 13;
    localparam int OUT_FIELD_BITS = STATUS_W + METHOD_W + 2 * VER_W + 5 * OUT_OFF_W;
    localparam int OUT_TDATA_W    = ((OUT_FIELD_BITS + 7) / 8) * 8;

    localparam logic [VER_W-1:0] VERSION_MAX = VER_W'(999);

    // characters
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_P     = 8'h50;

    // method names, first byte in the low bits
    localparam logic [23:0] NAME_GET  = 24'h544547;
    localparam logic [31:0] NAME_POST = 32'h54534F50;
    localparam logic [31:0] NAME_HEAD = 32'h44414548;

    typedef enum logic [STATUS_W-1:0] {
        ST_AGAIN       = 2'd0,
        ST_DONE        = 2'd1,
        ST_BAD_METHOD  = 2'd2,
        ST_BAD_REQUEST = 2'd3
    } status_t;

    typedef enum logic [METHOD_W-1:0] {
        METH_UNKNOWN = 2'd0,
        METH_GET     = 2'd1,
        METH_POST    = 2'd2,
        METH_HEAD    = 2'd3
    } method_t;

    typedef enum logic [14:0] {
        PH_START   = 15'b000000000000001,
        PH_METHOD  = 15'b000000000000010,
        PH_SP_URI  = 15'b000000000000100,
        PH_URI     = 15'b000000000001000,
        PH_SP_HTTP = 15'b000000000010000,
        PH_H       = 15'b000000000100000,
        PH_HT      = 15'b000000001000000,
        PH_HTT     = 15'b000000010000000,
        PH_HTTP    = 15'b000000100000000,
        PH_MAJ1    = 15'b000001000000000,
        PH_MAJ     = 15'b000010000000000,
        PH_MIN1    = 15'b000100000000000,
        PH_MIN     = 15'b001000000000000,
        PH_SP_END  = 15'b010000000000000,
        PH_ALMOST  = 15'b100000000000000
    } phase_t;

    function automatic logic is_upper(input logic [7:0] c);
        return (c >= CH_A) && (c <= CH_Z);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    // v * 10 + digit, saturating; v is at most 999 so 14 bits hold the sum
    function automatic logic [VER_W-1:0] add_digit(input logic [VER_W-1:0] v,
                                                   input logic [7:0] c);
        logic [13:0] n;
        n = ({4'd0, v} << 3) + ({4'd0, v} << 1) + {10'd0, c[3:0]};
        if (n > {4'd0, VERSION_MAX})
            return VERSION_MAX;
        return n[VER_W-1:0];
    endfunction

    function automatic method_t classify(input logic [31:0] bytes, input logic [2:0] len);
        if (len == 3'd3 && bytes[23:0] == NAME_GET)
            return METH_GET;
        if (len == 3'd4 && bytes == NAME_POST)
            return METH_POST;
        if (len == 3'd4 && bytes == NAME_HEAD)
            return METH_HEAD;
        return METH_UNKNOWN;
    endfunction

endpackage

### sv/http_request_line_parser_unit.sv
// top level: byte-serial http request line parser with registered stream ports
`timescale 1ns / 1ps

// path: an input transfer passes the input register, then the result register, to the master side
// throughput: one byte per cycle while the result side is not stalled; the byte state machine updates in a single pass
// an input register and a result register part the sides; a stalled result holds
// one byte in the input register, after that s_tready drops until m_tready returns
// reset: rst_n asynchronous, active low; parser returns to start phase, offsets zero
module http_request_line_parser_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // data_byte
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // status[1:0], method_code[3:2], version_major[13:4], version_minor[23:14],
    // line_start_offset[36:24], method_end_offset[49:37], uri_start_offset[62:50],
    // uri_end_offset[75:63], line_end_offset[88:76], zero pad above
    output logic [hrlp_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import hrlp_pkg::*;

    // input stage
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // result stage
    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    // parser state
    phase_t           phase_reg, phase_next;
    logic [OFF_W-1:0] off_reg, off_next;
    logic [31:0]      mbytes_reg, mbytes_next;
    logic [2:0]       mlen_reg, mlen_next;
    method_t          mkind_reg, mkind_next;
    logic [VER_W-1:0] major_reg, major_next;
    logic [VER_W-1:0] minor_reg, minor_next;
    logic [OFF_W-1:0] start_mark_reg, start_mark_next;
    logic [OFF_W-1:0] mend_mark_reg, mend_mark_next;
    logic [OFF_W-1:0] ustart_mark_reg, ustart_mark_next;
    logic [OFF_W-1:0] uend_mark_reg, uend_mark_next;
    logic [OFF_W-1:0] end_mark_reg, end_mark_next;

    status_t                st;
    logic [OUT_TDATA_W-1:0] result;
    logic                   advance;   // result register can take a new value
    logic                   proc;      // the held byte is processed this cycle
    logic [7:0]             c;
    logic                   take_method;

    assign advance  = !out_valid_reg || m_tready;
    assign proc     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign c        = in_byte_reg;

    // byte state machine, one pass per byte
    always_comb
    begin
        st               = ST_AGAIN;
        phase_next       = phase_reg;
        mbytes_next      = mbytes_reg;
        mlen_next        = mlen_reg;
        mkind_next       = mkind_reg;
        major_next       = major_reg;
        minor_next       = minor_reg;
        start_mark_next  = start_mark_reg;
        mend_mark_next   = mend_mark_reg;
        ustart_mark_next = ustart_mark_reg;
        uend_mark_next   = uend_mark_reg;
        end_mark_next    = end_mark_reg;

        // first four method bytes are kept, length saturates at seven
        take_method = 1'b0;

        case (phase_reg)
            PH_START:
            begin
                start_mark_next = off_reg;
                if (c == CH_CR || c == CH_LF)
                    phase_next = PH_START;
                else if (!is_upper(c))
                    st = ST_BAD_METHOD;
                else
                begin
                    take_method = 1'b1;
                    phase_next  = PH_METHOD;
                end
            end
            PH_METHOD:
            begin
                if (c == CH_SPACE)
                begin
                    mend_mark_next = off_reg;
                    mkind_next     = classify(mbytes_reg, mlen_reg);
                    phase_next     = PH_SP_URI;
                end
                else if (!is_upper(c))
                    st = ST_BAD_METHOD;
                else
                    take_method = 1'b1;
            end
            PH_SP_URI:
            begin
                if (c == CH_SLASH)
                begin
                    ustart_mark_next = off_reg;
                    phase_next       = PH_URI;
                end
                else if (c != CH_SPACE)
                    st = ST_BAD_REQUEST;
            end
            PH_URI:
            begin
                // any byte but a space belongs to the uri
                if (c == CH_SPACE)
                begin
                    uend_mark_next = off_reg;
                    phase_next     = PH_SP_HTTP;
                end
            end
            PH_SP_HTTP:
            begin
                if (c == CH_H)
                    phase_next = PH_H;
                else if (c != CH_SPACE)
                    st = ST_BAD_REQUEST;
            end
            PH_H:
            begin
                if (c == CH_T) phase_next = PH_HT;
                else           st = ST_BAD_REQUEST;
            end
            PH_HT:
            begin
                if (c == CH_T) phase_next = PH_HTT;
                else           st = ST_BAD_REQUEST;
            end
            PH_HTT:
            begin
                if (c == CH_P) phase_next = PH_HTTP;
                else           st = ST_BAD_REQUEST;
            end
            PH_HTTP:
            begin
                if (c == CH_SLASH) phase_next = PH_MAJ1;
                else               st = ST_BAD_REQUEST;
            end
            PH_MAJ1:
            begin
                // major version starts with a nonzero digit
                if (c < CH_1 || c > CH_9)
                    st = ST_BAD_REQUEST;
                else
                begin
                    major_next = {6'd0, c[3:0]};
                    phase_next = PH_MAJ;
                end
            end
            PH_MAJ:
            begin
                if (c == CH_DOT)
                    phase_next = PH_MIN1;
                else if (!is_digit(c))
                    st = ST_BAD_REQUEST;
                else
                    major_next = add_digit(major_reg, c);
            end
            PH_MIN1:
            begin
                if (!is_digit(c))
                    st = ST_BAD_REQUEST;
                else
                begin
                    minor_next = {6'd0, c[3:0]};
                    phase_next = PH_MIN;
                end
            end
            PH_MIN:
            begin
                if (c == CH_CR)
                begin
                    end_mark_next = off_reg;
                    phase_next    = PH_ALMOST;
                end
                else if (c == CH_LF)
                begin
                    end_mark_next = off_reg;
                    st            = ST_DONE;
                end
                else if (c == CH_SPACE)
                    phase_next = PH_SP_END;
                else if (!is_digit(c))
                    st = ST_BAD_REQUEST;
                else
                    minor_next = add_digit(minor_reg, c);
            end
            PH_SP_END:
            begin
                if (c == CH_CR)
                begin
                    end_mark_next = off_reg;
                    phase_next    = PH_ALMOST;
                end
                else if (c == CH_LF)
                begin
                    end_mark_next = off_reg;
                    st            = ST_DONE;
                end
                else if (c != CH_SPACE)
                    st = ST_BAD_REQUEST;
            end
            PH_ALMOST:
            begin
                st = (c == CH_LF) ? ST_DONE : ST_BAD_REQUEST;
            end
            default:
            begin
                st = ST_BAD_REQUEST;
            end
        endcase

        if (take_method)
        begin
            case (mlen_reg)
                3'd0:    mbytes_next = mbytes_reg | {24'd0, c};
                3'd1:    mbytes_next = mbytes_reg | {16'd0, c, 8'd0};
                3'd2:    mbytes_next = mbytes_reg | {8'd0, c, 16'd0};
                3'd3:    mbytes_next = mbytes_reg | {c, 24'd0};
                default: mbytes_next = mbytes_reg;
            endcase
            if (mlen_reg != 3'd7)
                mlen_next = mlen_reg + 3'd1;
        end

        // result shows the updated values, before any clearing
        result = OUT_TDATA_W'({
            OUT_OFF_W'(end_mark_next),
            OUT_OFF_W'(uend_mark_next),
            OUT_OFF_W'(ustart_mark_next),
            OUT_OFF_W'(mend_mark_next),
            OUT_OFF_W'(start_mark_next),
            minor_next,
            major_next,
            mkind_next,
            st
        });

        // done or error: the next byte begins a new line at offset zero
        off_next = off_reg;
        if (st != ST_AGAIN)
        begin
            phase_next       = PH_START;
            off_next         = '0;
            mbytes_next      = '0;
            mlen_next        = '0;
            mkind_next       = METH_UNKNOWN;
            major_next       = '0;
            minor_next       = '0;
            start_mark_next  = '0;
            mend_mark_next   = '0;
            ustart_mark_next = '0;
            uend_mark_next   = '0;
            end_mark_next    = '0;
        end
        else if (off_reg < OFFSET_MAX)
            off_next = off_reg + OFF_W'(1);
    end

    // handshake and parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            phase_reg       <= PH_START;
            off_reg         <= '0;
            mbytes_reg      <= '0;
            mlen_reg        <= '0;
            mkind_reg       <= METH_UNKNOWN;
            major_reg       <= '0;
            minor_reg       <= '0;
            start_mark_reg  <= '0;
            mend_mark_reg   <= '0;
            ustart_mark_reg <= '0;
            uend_mark_reg   <= '0;
            end_mark_reg    <= '0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= in_valid_reg;
            if (proc)
            begin
                phase_reg       <= phase_next;
                off_reg         <= off_next;
                mbytes_reg      <= mbytes_next;
                mlen_reg        <= mlen_next;
                mkind_reg       <= mkind_next;
                major_reg       <= major_next;
                minor_reg       <= minor_next;
                start_mark_reg  <= start_mark_next;
                mend_mark_reg   <= mend_mark_next;
                ustart_mark_reg <= ustart_mark_next;
                uend_mark_reg   <= uend_mark_next;
                end_mark_reg    <= end_mark_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_byte_reg <= s_tdata;
        if (proc)
            out_data_reg <= result;
    end

`ifndef NO_ASSERTIONS
    // a method error never carries a recognized method
    a_bad_method_unknown: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg[1:0] == ST_BAD_METHOD
        |-> out_data_reg[3:2] == METH_UNKNOWN)
        else $error("bad method result with a known method code");

    // a finished line always has a nonzero major version
    a_done_major: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg[1:0] == ST_DONE |-> out_data_reg[13:4] != '0)
        else $error("done result with zero major version");

    // a terminating byte puts the parser back at the start of a line
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        proc && st != ST_AGAIN |=> phase_reg == PH_START && off_reg == '0)
        else $error("parser not restarted after done or error");

    // the offset advances by one for every byte of an unfinished line
    a_offset_step: assert property (@(posedge clk) disable iff (!rst_n)
        proc && st == ST_AGAIN && off_reg < OFFSET_MAX
        |=> off_reg == $past(off_reg) + OFF_W'(1))
        else $error("byte offset did not advance");
`endif

endmodule

### bench/http_request_line_parser_checker.sv
// checker: predicts the parser result for every accepted byte and compares it with the result stream
`timescale 1ns / 1ps

module http_request_line_parser_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // data_byte
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [hrlp_pkg::OUT_TDATA_W-1:0] m_tdata,   // status up to line_end_offset, then zero pad
    output int                               failures,
    output int                               pending,
    output int                               lines_done,
    output int                               lines_rejected,
    output int                               results_checked
);
    import hrlp_pkg::*;

    // result fields, last field first so the cast matches the tdata packing
    typedef struct packed {
        logic [OUT_OFF_W-1:0] line_end;
        logic [OUT_OFF_W-1:0] uri_end;
        logic [OUT_OFF_W-1:0] path_start;
        logic [OUT_OFF_W-1:0] verb_end;
        logic [OUT_OFF_W-1:0] line_start;
        logic [VER_W-1:0]     minor;
        logic [VER_W-1:0]     major;
        method_t              method;
        status_t              status;
    } line_result_t;

    // method names, first byte in the low bits
    localparam logic [23:0] TEXT_GET  = {"T", "E", "G"};
    localparam logic [31:0] TEXT_POST = {"T", "S", "O", "P"};
    localparam logic [31:0] TEXT_HEAD = {"D", "A", "E", "H"};

    // parser state as the block should hold it
    phase_t               phase;
    logic [OFF_W-1:0]     offset;
    logic [31:0]          name_bytes;
    logic [2:0]           name_len;
    method_t              kind;
    logic [VER_W-1:0]     major_num;
    logic [VER_W-1:0]     minor_num;
    logic [OUT_OFF_W-1:0] start_at;
    logic [OUT_OFF_W-1:0] verb_end_at;
    logic [OUT_OFF_W-1:0] path_start_at;
    logic [OUT_OFF_W-1:0] uri_end_at;
    logic [OUT_OFF_W-1:0] end_at;

    line_result_t predicted_results[$];
    int fail_total;
    int done_total;
    int reject_total;
    int checked_total;

    function automatic void clear_parser();
        phase         = PH_START;
        offset        = '0;
        name_bytes    = '0;
        name_len      = '0;
        kind          = METH_UNKNOWN;
        major_num     = '0;
        minor_num     = '0;
        start_at      = '0;
        verb_end_at   = '0;
        path_start_at = '0;
        uri_end_at    = '0;
        end_at        = '0;
    endfunction

    // decimal accumulate with saturation at 999
    function automatic logic [VER_W-1:0] append_digit(input logic [VER_W-1:0] v,
                                                      input logic [7:0] c);
        int n;
        n = int'(v) * 10 + int'(c - CH_0);
        return (n > 999) ? VER_W'(999) : VER_W'(n);
    endfunction

    function automatic void keep_method_byte(input logic [7:0] c);
        if (name_len < 3'd4)
            name_bytes[8*name_len +: 8] = c;
        if (name_len != 3'd7)
            name_len = name_len + 3'd1;
    endfunction

    // one byte through the state machine, returns the result it causes
    function automatic line_result_t parse_byte(input logic [7:0] c);
        logic [OUT_OFF_W-1:0] pos;
        logic                 upper;
        logic                 digit;
        status_t              st;
        line_result_t         r;
        pos   = OUT_OFF_W'(offset);
        upper = (c >= CH_A) && (c <= CH_Z);
        digit = (c >= CH_0) && (c <= CH_9);
        st    = ST_AGAIN;
        case (phase)
            PH_START:
            begin
                start_at = pos;
                if (c == CH_CR || c == CH_LF)
                    st = ST_AGAIN;
                else if (!upper)
                    st = ST_BAD_METHOD;
                else
                begin
                    keep_method_byte(c);
                    phase = PH_METHOD;
                end
            end
            PH_METHOD:
            begin
                if (c == CH_SPACE)
                begin
                    verb_end_at = pos;
                    if (name_len == 3'd3 && name_bytes[23:0] == TEXT_GET)
                        kind = METH_GET;
                    else if (name_len == 3'd4 && name_bytes == TEXT_POST)
                        kind = METH_POST;
                    else if (name_len == 3'd4 && name_bytes == TEXT_HEAD)
                        kind = METH_HEAD;
                    else
                        kind = METH_UNKNOWN;
                    phase = PH_SP_URI;
                end
                else if (!upper)
                    st = ST_BAD_METHOD;
                else
                    keep_method_byte(c);
            end
            PH_SP_URI:
            begin
                if (c == CH_SLASH)
                begin
                    path_start_at = pos;
                    phase = PH_URI;
                end
                else if (c != CH_SPACE)
                    st = ST_BAD_REQUEST;
            end
            PH_URI:
            begin
                if (c == CH_SPACE)
                begin
                    uri_end_at = pos;
                    phase = PH_SP_HTTP;
                end
            end
            PH_SP_HTTP:
            begin
                if (c == CH_H)
                    phase = PH_H;
                else if (c != CH_SPACE)
                    st = ST_BAD_REQUEST;
            end
            PH_H:
                if (c == CH_T) phase = PH_HT; else st = ST_BAD_REQUEST;
            PH_HT:
                if (c == CH_T) phase = PH_HTT; else st = ST_BAD_REQUEST;
            PH_HTT:
                if (c == CH_P) phase = PH_HTTP; else st = ST_BAD_REQUEST;
            PH_HTTP:
                if (c == CH_SLASH) phase = PH_MAJ1; else st = ST_BAD_REQUEST;
            PH_MAJ1:
            begin
                if (c < CH_1 || c > CH_9)
                    st = ST_BAD_REQUEST;
                else
                begin
                    major_num = VER_W'(c - CH_0);
                    phase = PH_MAJ;
                end
            end
            PH_MAJ:
            begin
                if (c == CH_DOT)
                    phase = PH_MIN1;
                else if (!digit)
                    st = ST_BAD_REQUEST;
                else
                    major_num = append_digit(major_num, c);
            end
            PH_MIN1:
            begin
                if (!digit)
                    st = ST_BAD_REQUEST;
                else
                begin
                    minor_num = VER_W'(c - CH_0);
                    phase = PH_MIN;
                end
            end
            PH_MIN, PH_SP_END:
            begin
                if (c == CH_CR)
                begin
                    end_at = pos;
                    phase = PH_ALMOST;
                end
                else if (c == CH_LF)
                begin
                    end_at = pos;
                    st = ST_DONE;
                end
                else if (c == CH_SPACE)
                    phase = PH_SP_END;
                else if (phase == PH_SP_END || !digit)
                    st = ST_BAD_REQUEST;
                else
                    minor_num = append_digit(minor_num, c);
            end
            PH_ALMOST:
                st = (c == CH_LF) ? ST_DONE : ST_BAD_REQUEST;
            default:
                st = ST_BAD_REQUEST;
        endcase

        r.status     = st;
        r.method     = kind;
        r.major      = major_num;
        r.minor      = minor_num;
        r.line_start = start_at;
        r.verb_end   = verb_end_at;
        r.path_start = path_start_at;
        r.uri_end    = uri_end_at;
        r.line_end   = end_at;

        // a finished or rejected line starts over at offset zero
        if (st != ST_AGAIN)
            clear_parser();
        else if (offset != OFFSET_MAX)
            offset = offset + 1'b1;
        return r;
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] seen);
        if (seen !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, seen);
            fail_total++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        line_result_t want;
        line_result_t seen;
        if (!rst_n)
        begin
            clear_parser();
            predicted_results.delete();
            fail_total      = 0;
            done_total      = 0;
            reject_total    = 0;
            checked_total   = 0;
            failures        <= 0;
            pending         <= 0;
            lines_done      <= 0;
            lines_rejected  <= 0;
            results_checked <= 0;
        end
        else
        begin
            // result transfer, against the oldest prediction
            if (m_tvalid && m_tready)
            begin
                if (predicted_results.size() == 0)
                begin
                    $error("result transfer with no byte waiting for one");
                    fail_total++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    seen = line_result_t'(m_tdata[OUT_FIELD_BITS-1:0]);
                    compare_field("status", want.status, seen.status);
                    compare_field("method_code", want.method, seen.method);
                    compare_field("version_major", want.major, seen.major);
                    compare_field("version_minor", want.minor, seen.minor);
                    compare_field("line_start_offset", want.line_start, seen.line_start);
                    compare_field("method_end_offset", want.verb_end, seen.verb_end);
                    compare_field("uri_start_offset", want.path_start, seen.path_start);
                    compare_field("uri_end_offset", want.uri_end, seen.uri_end);
                    compare_field("line_end_offset", want.line_end, seen.line_end);
                    compare_field("pad", '0,
                                  32'(m_tdata[OUT_TDATA_W-1:OUT_FIELD_BITS]));
                    checked_total++;
                end
            end

            // byte transfer, predict what it gives
            if (s_tvalid && s_tready)
            begin
                want = parse_byte(s_tdata);
                if (want.status == ST_DONE)
                    done_total++;
                else if (want.status != ST_AGAIN)
                    reject_total++;
                predicted_results.push_back(want);
            end

            failures        <= fail_total;
            pending         <= predicted_results.size();
            lines_done      <= done_total;
            lines_rejected  <= reject_total;
            results_checked <= checked_total;
        end
    end

endmodule

### bench/http_request_line_parser_unit_test.sv
// testbench top: drives request line bytes into the parser and gives the verdict
`timescale 1ns / 1ps

module http_request_line_parser_unit_test;

    import hrlp_pkg::*;

    // worst case is far below this: ~1.1k bytes, each held up only by idle bursts and result stalls
    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int          TOTAL_BYTES = 1050;
    localparam int          QUIET_FROM  = 900;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata = 8'd0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    int failures;
    int pending;
    int lines_done;
    int lines_rejected;
    int results_checked;

    // idle bursts on both sides while set
    logic        bursts_on = 1'b0;
    int          bytes_sent = 0;
    int unsigned cycle_count = 0;
    int          stall_left = 0;
    logic [7:0]  line_bytes[$];

    always #5 clk = ~clk;

    http_request_line_parser_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    http_request_line_parser_checker checker_inst (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .failures        (failures),
        .pending         (pending),
        .lines_done      (lines_done),
        .lines_rejected  (lines_rejected),
        .results_checked (results_checked)
    );

    // hard stop if the result stream hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side back-pressure: random stall bursts
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (bursts_on && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 18);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // one byte transfer, with an optional idle burst ahead of it
    task automatic put_byte(input logic [7:0] b);
        if (bursts_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        bytes_sent++;
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_bytes.push_back(s[i]);
    endtask

    task automatic send_line();
        foreach (line_bytes[i])
            put_byte(line_bytes[i]);
        line_bytes.delete();
    endtask

    task automatic add_digits(input int count, input logic no_zero_first);
        for (int i = 0; i < count; i++)
            if (i == 0 && no_zero_first)
                line_bytes.push_back(8'($urandom_range(CH_1, CH_9)));
            else
                line_bytes.push_back(8'($urandom_range(CH_0, CH_9)));
    endtask

    // mostly well formed lines with random content, some corrupted, some pure noise
    task automatic build_random_line();
        logic [7:0] b;
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 8)) line_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        repeat ($urandom_range(0, 2))
            line_bytes.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
        case ($urandom_range(0, 5))
            0: add_text("GET");
            1: add_text("POST");
            2: add_text("HEAD");
            3:
            begin
                if ($urandom_range(0, 1))
                    add_text("POS");
                else
                    add_text("HEADER");
            end
            default:
                repeat ($urandom_range(1, 10))
                    line_bytes.push_back(8'($urandom_range(CH_A, CH_Z)));
        endcase
        repeat ($urandom_range(1, 3)) line_bytes.push_back(CH_SPACE);
        line_bytes.push_back(CH_SLASH);
        repeat ($urandom_range(0, 12))
        begin
            b = 8'($urandom_range(0, 255));
            line_bytes.push_back(b == CH_SPACE ? 8'h7E : b);
        end
        repeat ($urandom_range(1, 2)) line_bytes.push_back(CH_SPACE);
        add_text("HTTP/");
        add_digits($urandom_range(1, 5), 1'b1);
        line_bytes.push_back(CH_DOT);
        add_digits($urandom_range(1, 5), 1'b0);
        repeat ($urandom_range(0, 2)) line_bytes.push_back(CH_SPACE);
        if ($urandom_range(0, 1))
            line_bytes.push_back(CH_CR);
        line_bytes.push_back(CH_LF);
        // broken lines: one byte replaced by anything at all
        if ($urandom_range(0, 3) == 0)
            line_bytes[$urandom_range(0, line_bytes.size() - 1)] = 8'($urandom_range(0, 255));
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: the three methods, leading cr/lf, bare lf, extra spaces,
        // unknown and overlong method, lowercase method bytes, version saturation,
        // zero major digit, broken line ends and a broken protocol name
        add_text("GET / HTTP/1.1\015\n");
        add_text("\015\n\nPOST /a HTTP/1.0\n");
        add_text("HEAD  /x  HTTP/9.99  \015\n");
        add_text("PUT / HTTP/1.1 \n");
        add_text("ABCDEFGHIJ / HTTP/1.1\n");
        add_text("gGEt");
        add_text("GET x");
        add_text("GET / HTTP/12345.67890\n");
        add_text("GET / HTTP/0");
        add_text("GET / HTTP/1.1\015X");
        add_text("GET / HTTX");
        add_text("GET / HTTP/2.a");
        send_line();

        // random lines; idling comes and goes per line, none in the last stretch
        while (bytes_sent < TOTAL_BYTES)
        begin
            bursts_on = (bytes_sent < QUIET_FROM) && ($urandom_range(0, 3) != 0);
            build_random_line();
            send_line();
        end
        s_tvalid <= 1'b0;
        bursts_on = 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("checked %0d results: %0d request lines completed, %0d rejected",
                 results_checked, lines_done, lines_rejected);
        $display("covered all methods, version saturation, stalls and bad input");
        if (failures == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
